// ===== hdl/mms_pkg.sv =====
`timescale 1ns / 1ps

package mms_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned STAT_W  = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_POP  = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;

    localparam logic signed [WORD_W-1:0] EMPTY_READ = -32'sd1;

    // one stack level: stored value plus running min/max of it and all below
    typedef struct packed {
        logic signed [WORD_W-1:0] max_val;
        logic signed [WORD_W-1:0] min_val;
        logic signed [WORD_W-1:0] val;
    } mms_entry_t;

    typedef enum logic {
        S_IDLE,
        S_POP_WAIT
    } mms_state_t;

endpackage

// ===== hdl/mms_entry_ram.sv =====
`timescale 1ns / 1ps

module mms_entry_ram #(
    parameter int unsigned DEPTH = 128,
    parameter int unsigned IDX_W = 7
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  mms_pkg::mms_entry_t wr_data,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_addr,
    output mms_pkg::mms_entry_t rd_data
);
    import mms_pkg::*;

    mms_entry_t mem [DEPTH];
    mms_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/min_max_stack_unit.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Word contents (lowest bits first)
// s_axis   in   tuser: operation[1:0]; tdata: push_value[31:0]
// m_axis   out  tdata: read_value, min_value, max_value, entry_count;
//               tuser: status[1:0]
//
// Push, peek, a pop of the only entry and any request on an empty stack: the result
// is registered in the cycle after accept. A pop that leaves entries behind waits in
// S_POP_WAIT while the registered entry RAM read refills the cached top level.
// One request in flight at a time; a new word is taken while the previous
// result still sits in the output register only if that register drains.
// Reset clears the count and control; the RAM is not cleared (only levels
// below the count are read).
module min_max_stack_unit #(
    parameter int unsigned STACK_DEPTH = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [31:0]   s_axis_tdata,   // push_value[31:0]
    input  logic [1:0]    s_axis_tuser,   // operation[1:0]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [103:0]  m_axis_tdata,   // read_value[31:0], min_value[63:32],
                                          // max_value[95:64], entry_count[103:96]
    output logic [1:0]    m_axis_tuser    // status[1:0]
);
    import mms_pkg::*;

    localparam int unsigned IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

    // control
    mms_state_t       state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             out_valid_reg, out_valid_next;

    // cached top level and pending pop value
    mms_entry_t               top_reg, top_next;
    logic signed [WORD_W-1:0] pop_val_reg, pop_val_next;

    // output word
    logic signed [WORD_W-1:0] out_rd_reg, out_rd_next;
    logic signed [WORD_W-1:0] out_min_reg, out_min_next;
    logic signed [WORD_W-1:0] out_max_reg, out_max_next;
    logic [COUNT_W-1:0]       out_cnt_reg, out_cnt_next;
    logic [STAT_W-1:0]        out_st_reg, out_st_next;

    // RAM ports
    logic             wr_en, rd_en;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    mms_entry_t       wr_data, rd_data;

    logic                     in_hs;
    logic [OP_W-1:0]          op;
    logic signed [WORD_W-1:0] push_val;
    logic [CNT_W-1:0]         below_cnt;

    assign op       = s_axis_tuser;
    assign push_val = s_axis_tdata;
    assign s_axis_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_axis_tready);
    assign in_hs    = s_axis_tvalid && s_axis_tready;
    assign below_cnt = fill_reg - CNT_TWO;

    mms_entry_ram #(
        .DEPTH (STACK_DEPTH),
        .IDX_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        top_next       = top_reg;
        pop_val_next   = pop_val_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_rd_next    = out_rd_reg;
        out_min_next   = out_min_reg;
        out_max_next   = out_max_reg;
        out_cnt_next   = out_cnt_reg;
        out_st_next    = out_st_reg;
        wr_en          = 1'b0;
        wr_addr        = fill_reg[IDX_W-1:0];
        wr_data        = top_reg;
        rd_en          = 1'b0;
        rd_addr        = below_cnt[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_hs)
                begin
                    out_valid_next = 1'b1;
                    out_rd_next    = '0;
                    out_st_next    = ST_OK;
                    out_cnt_next   = COUNT_W'(fill_reg);
                    out_min_next   = (fill_reg == '0) ? '0 : top_reg.min_val;
                    out_max_next   = (fill_reg == '0) ? '0 : top_reg.max_val;
                    case (op)
                        OP_PUSH:
                        begin
                            if (fill_reg == FULL_CNT)
                            begin
                                out_st_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                top_next.val     = push_val;
                                top_next.min_val = push_val;
                                top_next.max_val = push_val;
                                if (fill_reg != '0)
                                begin
                                    if (top_reg.min_val < push_val)
                                        top_next.min_val = top_reg.min_val;
                                    if (top_reg.max_val > push_val)
                                        top_next.max_val = top_reg.max_val;
                                end
                                wr_en        = 1'b1;
                                wr_data      = top_next;
                                fill_next    = fill_reg + CNT_ONE;
                                out_cnt_next = COUNT_W'(fill_next);
                                out_min_next = top_next.min_val;
                                out_max_next = top_next.max_val;
                            end
                        end
                        OP_POP:
                        begin
                            if (fill_reg == '0)
                            begin
                                out_rd_next = EMPTY_READ;
                                out_st_next = ST_EMPTY;
                            end
                            else
                            begin
                                fill_next    = fill_reg - CNT_ONE;
                                out_rd_next  = top_reg.val;
                                out_cnt_next = COUNT_W'(fill_next);
                                out_min_next = '0;
                                out_max_next = '0;
                                if (fill_reg != CNT_ONE)
                                begin
                                    // new top comes back from RAM next cycle
                                    rd_en          = 1'b1;
                                    pop_val_next   = top_reg.val;
                                    out_valid_next = 1'b0;
                                    state_next     = S_POP_WAIT;
                                end
                            end
                        end
                        default:
                        begin
                            // peek; the unused code behaves the same
                            if (fill_reg == '0)
                            begin
                                out_rd_next = EMPTY_READ;
                                out_st_next = ST_EMPTY;
                            end
                            else
                            begin
                                out_rd_next = top_reg.val;
                            end
                        end
                    endcase
                end
            end
            S_POP_WAIT:
            begin
                // output register is free: it was drained when the pop was taken
                top_next       = rd_data;
                out_valid_next = 1'b1;
                out_rd_next    = pop_val_reg;
                out_min_next   = rd_data.min_val;
                out_max_next   = rd_data.max_val;
                out_cnt_next   = COUNT_W'(fill_reg);
                out_st_next    = ST_OK;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg     <= top_next;
        pop_val_reg <= pop_val_next;
        out_rd_reg  <= out_rd_next;
        out_min_reg <= out_min_next;
        out_max_reg <= out_max_next;
        out_cnt_reg <= out_cnt_next;
        out_st_reg  <= out_st_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_cnt_reg, out_max_reg, out_min_reg, out_rd_reg};
    assign m_axis_tuser  = out_st_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_CNT)
        else $error("fill count above depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        in_hs && op == OP_PUSH && fill_reg != FULL_CNT |=> fill_reg == $past(fill_reg) + CNT_ONE)
        else $error("push did not grow the stack");

    a_pop_wait_one: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POP_WAIT |=> state_reg == S_IDLE && out_valid_reg)
        else $error("pop refill did not produce a result");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_st_reg == ST_EMPTY |-> fill_reg == '0 && out_min_reg == '0)
        else $error("empty status with stored entries");
`endif

endmodule
